[src/lz77te_pkg.sv]
// shared types and constants of the lz77 token encoder
`default_nettype none

package lz77te_pkg;

  localparam int unsigned DICT_SIZE_DEF      = 9;
  localparam int unsigned LOOKAHEAD_SIZE_DEF = 9;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_OUT_W = 4;
  localparam int unsigned LEN_OUT_W = 4;

  localparam logic [BYTE_W-1:0] PREFILL_RESET = 8'd48;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register word index, taken from paddr[PADDR_W-1:2]
  localparam logic [PADDR_W-3:0] REG_PREFILL_IDX = 1'b0;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic load_search;
    logic scan_done;
    logic out_stall;
    logic more_tokens;
  } dp_status_t;

endpackage

`default_nettype wire

[src/lz77te_if.sv]
// valid/ready channel interfaces for input bytes and output tokens
`default_nettype none

interface lz77te_in_if;
  import lz77te_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface lz77te_out_if;
  import lz77te_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] match_position;
  logic [LEN_OUT_W-1:0] match_length;
  byte_t                next_byte;
  logic                 last_token;

  modport source (output valid, output match_position, output match_length,
                  output next_byte, output last_token, input ready);
  modport sink   (input valid, input match_position, input match_length,
                  input next_byte, input last_token, output ready);
endinterface

`default_nettype wire

[src/lz77_token_encoder_unit.sv]
// lz77 token encoder top level: channels, config registers, controller and datapath
//
// bytes enter on in_if (data_byte, end_of_input); a transfer happens when
// valid and ready are both high. tokens leave on out_if as match_position,
// match_length, next_byte and last_token under the same valid/ready rule.
// the apb port holds one register, the dictionary fill byte at address 0,
// used when the next stream starts (first byte after reset or after end).
// no token comes out until the lookahead holds LOOKAHEAD_SIZE bytes or a
// byte with end_of_input is taken; a byte that does neither is taken with
// no search. each token is found by a sweep over the dictionary start
// positions, one position per cycle through the single lookahead
// comparator, then the output register is written and the window slides.
// the first token shows on out_if after the sweep and emit step that follow
// the byte transfer that fills the lookahead. a byte with end_of_input
// flushes up to LOOKAHEAD_SIZE tokens back to back, the last one marked.
// in_if.ready is high only while no search is running. if the receiver
// stalls, the finished token waits in the output register while the next
// search runs, and the block then holds until that register is free.
// reset clears all control state and the fill byte returns to '0'.
`default_nettype none

module lz77_token_encoder_unit #(
  parameter int unsigned DICT_SIZE      = lz77te_pkg::DICT_SIZE_DEF,
  parameter int unsigned LOOKAHEAD_SIZE = lz77te_pkg::LOOKAHEAD_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lz77te_in_if.sink                      in_if,
  lz77te_out_if.source                   out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lz77te_pkg::PADDR_W-1:0] paddr,
  input  logic [lz77te_pkg::PDATA_W-1:0] pwdata,
  output logic [lz77te_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import lz77te_pkg::*;

  byte_t      prefill_byte;
  dp_cmd_t    cmd;
  dp_status_t status;

  lz77te_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .prefill_byte_o (prefill_byte)
  );

  lz77te_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lz77te_dp #(
    .DICT_SIZE      (DICT_SIZE),
    .LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .data_byte_i      (in_if.data_byte),
    .end_of_input_i   (in_if.end_of_input),
    .prefill_byte_i   (prefill_byte),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .match_position_o (out_if.match_position),
    .match_length_o   (out_if.match_length),
    .next_byte_o      (out_if.next_byte),
    .last_token_o     (out_if.last_token)
  );

endmodule

`default_nettype wire

[src/lz77te_cfg.sv]
// apb register block holding the dictionary fill byte
`default_nettype none

module lz77te_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lz77te_pkg::PADDR_W-1:0]    paddr,
  input  logic [lz77te_pkg::PDATA_W-1:0]    pwdata,
  output logic [lz77te_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready,
  output lz77te_pkg::byte_t                 prefill_byte_o
);
  import lz77te_pkg::*;

  byte_t prefill_q;
  logic  sel_prefill;

  assign sel_prefill = (paddr[PADDR_W-1:2] == REG_PREFILL_IDX);
  assign pready      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefill_q <= PREFILL_RESET;
    end else if (psel && penable && pwrite && pready && sel_prefill) begin
      prefill_q <= pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_prefill) begin
      prdata = PDATA_W'(prefill_q);
    end
  end

  assign prefill_byte_o = prefill_q;

endmodule

`default_nettype wire

[src/lz77te_ctrl.sv]
// controller state machine sequencing load, search sweep and token transfer
`default_nettype none

module lz77te_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lz77te_pkg::dp_status_t status_i,
  output lz77te_pkg::dp_cmd_t    cmd_o
);
  import lz77te_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.load_search) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_stall) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.more_tokens ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/lz77te_dp.sv]
// datapath: sliding window, serial match sweep and output token register
`default_nettype none

module lz77te_dp #(
  parameter int unsigned DICT_SIZE      = lz77te_pkg::DICT_SIZE_DEF,
  parameter int unsigned LOOKAHEAD_SIZE = lz77te_pkg::LOOKAHEAD_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lz77te_pkg::dp_cmd_t                  cmd_i,
  output lz77te_pkg::dp_status_t               status_o,
  input  lz77te_pkg::byte_t                    data_byte_i,
  input  logic                                 end_of_input_i,
  input  lz77te_pkg::byte_t                    prefill_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lz77te_pkg::POS_OUT_W-1:0]     match_position_o,
  output logic [lz77te_pkg::LEN_OUT_W-1:0]     match_length_o,
  output lz77te_pkg::byte_t                    next_byte_o,
  output logic                                 last_token_o
);
  import lz77te_pkg::*;

  localparam int unsigned TOTAL = DICT_SIZE + LOOKAHEAD_SIZE;
  localparam int unsigned CNT_W = $clog2(LOOKAHEAD_SIZE + 1);
  localparam int unsigned LEN_W = $clog2(LOOKAHEAD_SIZE);
  localparam int unsigned POS_W = (DICT_SIZE > 1) ? $clog2(DICT_SIZE) : 1;
  localparam int unsigned CMP_N = LOOKAHEAD_SIZE - 1;

  byte_t window_q [TOTAL];
  byte_t window_d [TOTAL];
  byte_t scan_q   [TOTAL];
  byte_t scan_d   [TOTAL];
  byte_t loaded   [TOTAL];
  byte_t slid     [TOTAL];

  logic [CNT_W-1:0] count_q, count_d;
  logic             in_stream_q, in_stream_d;
  logic             eoi_q, eoi_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] best_len_q, best_len_d;
  logic [POS_W-1:0] best_pos_q, best_pos_d;
  logic             out_valid_q;

  logic [POS_OUT_W-1:0] match_position_q;
  logic [LEN_OUT_W-1:0] match_length_q;
  byte_t                next_byte_q;
  logic                 last_token_q;

  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] count_ld;
  logic [CNT_W-1:0] cap_w;
  logic [LEN_W-1:0] cap;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] count_after;
  logic [CMP_N-1:0] run_ok;
  logic [LEN_W-1:0] cur_len;
  byte_t            literal;
  logic             load_search;
  logic             more_tokens;
  logic             restart;
  logic [31:0]      pos_plus;
  logic [31:0]      len_ext;

  assign count_eff   = in_stream_q ? count_q : '0;
  assign count_ld    = count_eff + CNT_W'(1);
  assign load_search = end_of_input_i || (count_ld == CNT_W'(LOOKAHEAD_SIZE));
  assign cap_w       = count_q - CNT_W'(1);
  assign cap         = cap_w[LEN_W-1:0];
  assign step        = CNT_W'(best_len_q) + CNT_W'(1);
  assign count_after = count_q - step;
  assign more_tokens = eoi_q && (count_after != '0);
  assign restart     = (cmd_i.load && load_search) || (cmd_i.emit && more_tokens);

  assign status_o.load_search = load_search;
  assign status_o.scan_done   = (pos_q == POS_W'(DICT_SIZE - 1));
  assign status_o.out_stall   = out_valid_q && !out_ready_i;
  assign status_o.more_tokens = more_tokens;

  // match run of the current start position against the lookahead
  always_comb begin
    for (int j = 0; j < CMP_N; j++) begin
      run_ok[j] = (scan_q[j] == window_q[DICT_SIZE + j]) && (LEN_W'(j) < cap);
    end
    cur_len = cap;
    for (int j = CMP_N - 1; j >= 0; j--) begin
      if (!run_ok[j]) begin
        cur_len = LEN_W'(j);
      end
    end
  end

  always_comb begin
    literal = window_q[DICT_SIZE];
    for (int j = 0; j < LOOKAHEAD_SIZE; j++) begin
      if (best_len_q == LEN_W'(j)) begin
        literal = window_q[DICT_SIZE + j];
      end
    end
  end

  // window after a byte transfer in, and after a slide by length plus one
  always_comb begin
    for (int k = 0; k < TOTAL; k++) begin
      if (k < DICT_SIZE) begin
        loaded[k] = in_stream_q ? window_q[k] : prefill_byte_i;
      end else if (count_eff == CNT_W'(k - DICT_SIZE)) begin
        loaded[k] = data_byte_i;
      end else begin
        loaded[k] = window_q[k];
      end
      slid[k] = window_q[k];
      for (int s = 1; s <= LOOKAHEAD_SIZE; s++) begin
        if (k + s < TOTAL) begin
          if (step == CNT_W'(s)) begin
            slid[k] = window_q[k + s];
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TOTAL; k++) begin
      if (cmd_i.load) begin
        window_d[k] = loaded[k];
      end else if (cmd_i.emit) begin
        window_d[k] = slid[k];
      end else begin
        window_d[k] = window_q[k];
      end
    end
    for (int k = 0; k < TOTAL; k++) begin
      if (restart) begin
        scan_d[k] = window_d[k];
      end else if (cmd_i.scan && (k + 1 < TOTAL)) begin
        scan_d[k] = scan_q[(k + 1) % TOTAL];
      end else begin
        scan_d[k] = scan_q[k];
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    in_stream_d = in_stream_q;
    eoi_d       = eoi_q;
    pos_d       = pos_q;
    best_len_d  = best_len_q;
    best_pos_d  = best_pos_q;
    if (cmd_i.load) begin
      count_d     = count_ld;
      in_stream_d = 1'b1;
      eoi_d       = end_of_input_i;
    end
    if (cmd_i.emit) begin
      count_d = count_after;
      if (eoi_q && !more_tokens) begin
        in_stream_d = 1'b0;
      end
    end
    if (restart) begin
      pos_d      = '0;
      best_len_d = '0;
      best_pos_d = '0;
    end else if (cmd_i.scan) begin
      pos_d = pos_q + POS_W'(1);
      if (cur_len >= best_len_q) begin
        best_len_d = cur_len;
        best_pos_d = pos_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      in_stream_q <= 1'b0;
      eoi_q       <= 1'b0;
      pos_q       <= '0;
      best_len_q  <= '0;
      best_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      in_stream_q <= in_stream_d;
      eoi_q       <= eoi_d;
      pos_q       <= pos_d;
      best_len_q  <= best_len_d;
      best_pos_q  <= best_pos_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pos_plus = 32'(best_pos_q) + 32'd1;
  assign len_ext  = 32'(best_len_q);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TOTAL; k++) begin
      window_q[k] <= window_d[k];
      scan_q[k]   <= scan_d[k];
    end
    if (cmd_i.emit) begin
      match_position_q <= pos_plus[POS_OUT_W-1:0];
      match_length_q   <= len_ext[LEN_OUT_W-1:0];
      next_byte_q      <= literal;
      last_token_q     <= eoi_q && !more_tokens;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_position_o = match_position_q;
  assign match_length_o   = match_length_q;
  assign next_byte_o      = next_byte_q;
  assign last_token_o     = last_token_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LOOKAHEAD_SIZE))
    else $error("lookahead count beyond lookahead size");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("token overwrote a result still waiting for transfer");

  a_match_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (CNT_W'(best_len_q) < count_q))
    else $error("match length not below bytes held");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && eoi_q && !more_tokens) |=> (!in_stream_q && out_valid_q && last_token_q))
    else $error("final token did not close the stream");
`endif

endmodule

`default_nettype wire
